// ===== hw/rtl/rational_arithmetic_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define RAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define RAU_ASSERT(lbl, prop, msg)
`define RAU_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Word width, operation codes and the request and status types of the
// shared multiply and divide unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

  localparam logic [3:0] OP_ADD    = 4'd0;
  localparam logic [3:0] OP_SUB    = 4'd1;
  localparam logic [3:0] OP_MUL    = 4'd2;
  localparam logic [3:0] OP_DIV    = 4'd3;
  localparam logic [3:0] OP_NEG    = 4'd4;
  localparam logic [3:0] OP_REDUCE = 4'd5;
  localparam logic [3:0] OP_EQ     = 4'd6;
  localparam logic [3:0] OP_GT     = 4'd7;
  localparam logic [3:0] OP_TOINT  = 4'd8;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef struct packed {
    logic start;
    logic is_div;
  } rau_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rau_sts_t;

  // Magnitude of a two's complement word; the most negative value maps to
  // its unsigned magnitude.
  function automatic word_t mag_f(word_t x);
    return x[WORD_BITS-1] ? word_t'(-x) : x;
  endfunction

  function automatic word_t negif_f(logic neg, word_t x);
    return neg ? word_t'(-x) : x;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rau_muldiv.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit multiply and divide engine
// Unsigned shift-add multiplier and restoring divider sharing one register set,
// one bit per cycle while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_muldiv (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire rau_pkg::rau_req_t req_i,
  input  wire rau_pkg::word_t   a_i,
  input  wire rau_pkg::word_t   b_i,
  output rau_pkg::rau_sts_t     sts_o,
  output rau_pkg::word_t        prod_hi_o,
  output rau_pkg::word_t        prod_lo_o,
  output rau_pkg::word_t        rem_o
);
  import rau_pkg::*;

  word_t                hi_q, hi_d;
  word_t                lo_q, lo_d;
  word_t                b_q;
  logic                 div_q;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 busy_q, busy_d, done_q, done_d;
  logic [WORD_BITS:0]   sum, sh;
  logic                 ge;

  always_comb begin
    sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, b_q} : '0);
    sh  = {hi_q, lo_q[WORD_BITS-1]};
    ge  = sh >= {1'b0, b_q};
    hi_d = hi_q;
    lo_d = lo_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      hi_d = '0;
      lo_d = a_i;
      cnt_d = CNT_BITS'(WORD_BITS);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (div_q) begin
        // The partial remainder stays below the divisor, so it fits a word.
        hi_d = ge ? word_t'(sh - {1'b0, b_q}) : sh[WORD_BITS-1:0];
        lo_d = {lo_q[WORD_BITS-2:0], ge};
      end else begin
        hi_d = sum[WORD_BITS:1];
        lo_d = {sum[0], lo_q[WORD_BITS-1:1]};
      end
      cnt_d = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q <= hi_d;
    lo_q <= lo_d;
    if (req_i.start) begin
      b_q   <= b_i;
      div_q <= req_i.is_div;
    end
  end

  assign sts_o     = '{busy: busy_q, done: done_q};
  assign prod_hi_o = hi_q;
  assign prod_lo_o = lo_q;
  assign rem_o     = hi_q;

endmodule

`default_nettype wire

// ===== hw/rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add, subtract, multiply, divide, negate, reduce, compare and
// integer conversion over 32-bit wrapping numerators and denominators.
// ----------------------------------------------------------------------------
// One word in gives one result word. Negate and unused codes finish straight
// from the idle state, as do add, subtract, reduce, compares and to_int when
// an operand denominator that they read is zero. All other work runs through
// one shared multiply and divide engine: multiply and divide take two engine
// operations, compares two and to_int one, reduce a Euclid gcd of one
// division per step plus two divisions, and add and subtract a gcd plus six
// engine operations. The input is stalled while a word is in progress; a
// finished result is held in the output register, and the next word is taken
// no earlier than the edge at which that result leaves.
`default_nettype none

module rational_arithmetic_unit (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic [3:0]     op_i,
  input  wire rau_pkg::word_t a_num_i,
  input  wire rau_pkg::word_t a_den_i,
  input  wire rau_pkg::word_t b_num_i,
  input  wire rau_pkg::word_t b_den_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output rau_pkg::word_t      res_num_o,
  output rau_pkg::word_t      res_den_o,
  output logic                cmp_true_o,
  output logic                zero_den_o
);
  import rau_pkg::*;
  `include "rational_arithmetic_unit_defines.svh"

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_GCD_CHK = 4'd1;
  localparam logic [3:0] S_GCD_DIV = 4'd2;
  localparam logic [3:0] S_LCM_DIV = 4'd3;
  localparam logic [3:0] S_LCM_MUL = 4'd4;
  localparam logic [3:0] S_FA_DIV  = 4'd5;
  localparam logic [3:0] S_P1_MUL  = 4'd6;
  localparam logic [3:0] S_FB_DIV  = 4'd7;
  localparam logic [3:0] S_P2_MUL  = 4'd8;
  localparam logic [3:0] S_M1      = 4'd9;
  localparam logic [3:0] S_M2      = 4'd10;
  localparam logic [3:0] S_RED_N   = 4'd11;
  localparam logic [3:0] S_RED_D   = 4'd12;
  localparam logic [3:0] S_CMP1    = 4'd13;
  localparam logic [3:0] S_CMP2    = 4'd14;
  localparam logic [3:0] S_TOINT   = 4'd15;

  logic [3:0] state_q, state_d;
  logic       issued_q, issued_d;
  logic       out_valid_q;
  logic [3:0] op_q;
  word_t      an_q, ad_q, bn_q, bd_q;
  word_t      wa_q, wa_d, wb_q, wb_d, lcm_q, lcm_d;
  logic [2*WORD_BITS-1:0] p1_q, p1_d;
  word_t      res_num_q, res_den_q;
  logic       cmp_q, zd_q;

  rau_req_t   req;
  rau_sts_t   sts;
  word_t      eng_a, eng_b, prod_hi, prod_lo, rem;
  logic       accept, fin;
  word_t      f_rn, f_rd;
  logic       f_cmp, f_zd;
  word_t      sq, rn0, rd0;
  logic [2*WORD_BITS:0] v1, v2;
  logic       n1, n2, gt, lt;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);

  rau_muldiv u_muldiv (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .a_i       (eng_a),
    .b_i       (eng_b),
    .sts_o     (sts),
    .prod_hi_o (prod_hi),
    .prod_lo_o (prod_lo),
    .rem_o     (rem)
  );

  // Engine operands for each working state.
  always_comb begin
    eng_a = '0;
    eng_b = '0;
    req.is_div = 1'b0;
    case (state_q)
      S_GCD_DIV: begin
        eng_a = wa_q; eng_b = wb_q; req.is_div = 1'b1;
      end
      S_LCM_DIV: begin
        eng_a = mag_f(ad_q); eng_b = wa_q; req.is_div = 1'b1;
      end
      S_LCM_MUL: begin
        eng_a = wb_q; eng_b = mag_f(bd_q);
      end
      S_FA_DIV: begin
        eng_a = mag_f(lcm_q); eng_b = mag_f(ad_q); req.is_div = 1'b1;
      end
      S_P1_MUL: begin
        eng_a = wa_q; eng_b = an_q;
      end
      S_FB_DIV: begin
        eng_a = mag_f(lcm_q); eng_b = mag_f(bd_q); req.is_div = 1'b1;
      end
      S_P2_MUL: begin
        eng_a = wa_q; eng_b = bn_q;
      end
      S_M1: begin
        eng_a = an_q; eng_b = (op_q == OP_MUL) ? bn_q : bd_q;
      end
      S_M2: begin
        eng_a = ad_q; eng_b = (op_q == OP_MUL) ? bd_q : bn_q;
      end
      S_RED_N: begin
        eng_a = mag_f(an_q); eng_b = wa_q; req.is_div = 1'b1;
      end
      S_RED_D: begin
        eng_a = mag_f(ad_q); eng_b = wa_q; req.is_div = 1'b1;
      end
      S_CMP1: begin
        eng_a = mag_f(an_q); eng_b = mag_f(bd_q);
      end
      S_CMP2: begin
        eng_a = mag_f(bn_q); eng_b = mag_f(ad_q);
      end
      S_TOINT: begin
        eng_a = mag_f(an_q); eng_b = mag_f(ad_q); req.is_div = 1'b1;
      end
      default: ;
    endcase
    req.start = (state_q != S_IDLE) && (state_q != S_GCD_CHK) && !issued_q;
  end

  always_comb begin
    state_d = state_q;
    issued_d = issued_q;
    wa_d = wa_q;
    wb_d = wb_q;
    lcm_d = lcm_q;
    p1_d = p1_q;
    fin = 1'b0;
    f_rn = '0;
    f_rd = '0;
    f_cmp = 1'b0;
    f_zd = 1'b0;
    sq = '0;
    rn0 = '0;
    rd0 = '0;
    v1 = '0;
    v2 = '0;
    n1 = 1'b0;
    n2 = 1'b0;
    gt = 1'b0;
    lt = 1'b0;
    if (req.start) begin
      issued_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_ADD, OP_SUB: begin
              if (a_den_i == '0 || b_den_i == '0) begin
                fin = 1'b1; f_zd = 1'b1;
              end else begin
                wa_d = mag_f(a_den_i); wb_d = mag_f(b_den_i); state_d = S_GCD_CHK;
              end
            end
            OP_MUL, OP_DIV: state_d = S_M1;
            OP_NEG: begin
              fin = 1'b1; f_rn = word_t'(-a_num_i); f_rd = a_den_i;
              f_zd = (a_den_i == '0);
            end
            OP_REDUCE: begin
              if (a_den_i == '0) begin
                fin = 1'b1; f_rn = a_num_i; f_zd = 1'b1;
              end else begin
                wa_d = mag_f(a_num_i); wb_d = mag_f(a_den_i); state_d = S_GCD_CHK;
              end
            end
            OP_EQ, OP_GT: begin
              if (a_den_i == '0 || b_den_i == '0) begin
                fin = 1'b1; f_zd = 1'b1;
              end else begin
                state_d = S_CMP1;
              end
            end
            OP_TOINT: begin
              if (a_den_i == '0) begin
                fin = 1'b1; f_rd = word_t'(1); f_zd = 1'b1;
              end else begin
                state_d = S_TOINT;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      S_GCD_CHK: begin
        // A zero remainder leaves the gcd in wa.
        if (wb_q == '0) begin
          state_d = (op_q == OP_REDUCE) ? S_RED_N : S_LCM_DIV;
        end else begin
          state_d = S_GCD_DIV;
        end
      end
      default: begin
        if (issued_q && sts.done) begin
          issued_d = 1'b0;
          case (state_q)
            S_GCD_DIV: begin
              wa_d = wb_q; wb_d = rem; state_d = S_GCD_CHK;
            end
            S_LCM_DIV: begin
              wb_d = prod_lo; state_d = S_LCM_MUL;
            end
            S_LCM_MUL: begin
              lcm_d = prod_lo; state_d = S_FA_DIV;
            end
            S_FA_DIV: begin
              wa_d = negif_f(lcm_q[WORD_BITS-1] ^ ad_q[WORD_BITS-1], prod_lo);
              state_d = S_P1_MUL;
            end
            S_P1_MUL: begin
              p1_d = {{WORD_BITS{1'b0}}, prod_lo}; state_d = S_FB_DIV;
            end
            S_FB_DIV: begin
              wa_d = negif_f(lcm_q[WORD_BITS-1] ^ bd_q[WORD_BITS-1], prod_lo);
              state_d = S_P2_MUL;
            end
            S_P2_MUL: begin
              fin = 1'b1;
              f_rn = (op_q == OP_SUB) ? p1_q[WORD_BITS-1:0] - prod_lo
                                      : p1_q[WORD_BITS-1:0] + prod_lo;
              f_rd = lcm_q;
              f_zd = (lcm_q == '0);
            end
            S_M1: begin
              p1_d = {{WORD_BITS{1'b0}}, prod_lo}; state_d = S_M2;
            end
            S_M2: begin
              fin = 1'b1;
              f_rn = p1_q[WORD_BITS-1:0];
              f_rd = prod_lo;
              f_zd = (ad_q == '0) || (bd_q == '0) || (prod_lo == '0);
            end
            S_RED_N: begin
              wb_d = prod_lo; state_d = S_RED_D;
            end
            S_RED_D: begin
              rn0 = negif_f(an_q[WORD_BITS-1], wb_q);
              rd0 = negif_f(ad_q[WORD_BITS-1], prod_lo);
              fin = 1'b1;
              f_rn = negif_f(rd0[WORD_BITS-1], rn0);
              f_rd = negif_f(rd0[WORD_BITS-1], rd0);
              f_zd = (f_rd == '0);
            end
            S_CMP1: begin
              p1_d = {prod_hi, prod_lo}; state_d = S_CMP2;
            end
            S_CMP2: begin
              // Signed products a_num*b_den and b_num*a_den, compared exactly.
              n1 = (p1_q != '0) && (an_q[WORD_BITS-1] ^ bd_q[WORD_BITS-1]);
              n2 = ({prod_hi, prod_lo} != '0) && (bn_q[WORD_BITS-1] ^ ad_q[WORD_BITS-1]);
              v1 = n1 ? -{1'b0, p1_q} : {1'b0, p1_q};
              v2 = n2 ? -{1'b0, prod_hi, prod_lo} : {1'b0, prod_hi, prod_lo};
              gt = $signed(v1) > $signed(v2);
              lt = $signed(v1) < $signed(v2);
              fin = 1'b1;
              if (op_q == OP_EQ) begin
                f_cmp = (v1 == v2);
              end else begin
                f_cmp = (ad_q[WORD_BITS-1] ^ bd_q[WORD_BITS-1]) ? lt : gt;
              end
            end
            S_TOINT: begin
              sq = negif_f(an_q[WORD_BITS-1] ^ ad_q[WORD_BITS-1], prod_lo);
              fin = 1'b1; f_rn = sq; f_rd = word_t'(1);
            end
            default: ;
          endcase
          if (fin) begin
            state_d = S_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (fin) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_i;
      an_q <= a_num_i;
      ad_q <= a_den_i;
      bn_q <= b_num_i;
      bd_q <= b_den_i;
    end
    wa_q  <= wa_d;
    wb_q  <= wb_d;
    lcm_q <= lcm_d;
    p1_q  <= p1_d;
    if (fin) begin
      res_num_q <= f_rn;
      res_den_q <= f_rd;
      cmp_q     <= f_cmp;
      zd_q      <= f_zd;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign cmp_true_o  = cmp_q;
  assign zero_den_o  = zd_q;

  // An accepted word either finishes at once or keeps the sequencer busy.
  `RAU_ASSERT(a_accept_progress, accept |=> (state_q != S_IDLE) || out_valid_o, "accepted word lost")
  // The engine is only started when it is free.
  `RAU_ASSERT(a_start_free, req.start |-> !sts.busy, "engine started while busy")
  // A new result only appears from a finishing step.
  `RAU_ASSERT(a_result_source, $rose(out_valid_o) |-> $past(fin), "result without finish")
  // No word is taken while the sequencer is working.
  `RAU_ASSERT(a_busy_stall, (state_q != S_IDLE) |-> in_stall_o, "word taken while busy")

endmodule

`default_nettype wire

// ===== tb/rational_arithmetic_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives operation words through the unit with random idling on both sides
// and checks every result word against a fraction arithmetic predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module rational_arithmetic_unit_tb;
  import rau_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [31:0] den;
    logic        cmp;
    logic        zd;
  } frac_res_t;

  // Magnitude, quotient and gcd helpers at 32 bits.
  function automatic logic [31:0] mag32(logic [31:0] x);
    return x[31] ? -x : x;
  endfunction

  function automatic logic [31:0] quot32(logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    if (b == 0) return 32'd0;
    q = mag32(a) / mag32(b);
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic logic [31:0] euclid(logic [31:0] x, logic [31:0] y);
    logic [31:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t rational_op(logic [3:0] op, logic [31:0] an,
                                            logic [31:0] ad, logic [31:0] bn,
                                            logic [31:0] bd);
    frac_res_t r;
    logic [31:0] l, g, ma, mb;
    logic signed [64:0] p1, p2;
    r = '{32'd0, 32'd0, 1'b0, 1'b0};
    case (op)
      OP_ADD, OP_SUB: begin
        ma = mag32(ad);
        mb = mag32(bd);
        l  = (ma == 0 || mb == 0) ? 32'd0 : (ma / euclid(ma, mb)) * mb;
        r.den = l;
        if (op == OP_ADD)
          r.num = quot32(l, ad) * an + quot32(l, bd) * bn;
        else
          r.num = quot32(l, ad) * an - quot32(l, bd) * bn;
        r.zd = (ad == 0 || bd == 0 || l == 0);
      end
      OP_MUL: begin
        r.num = an * bn;
        r.den = ad * bd;
        r.zd  = (ad == 0 || bd == 0 || r.den == 0);
      end
      OP_DIV: begin
        r.num = an * bd;
        r.den = ad * bn;
        r.zd  = (ad == 0 || bd == 0 || r.den == 0);
      end
      OP_NEG: begin
        r.num = -an;
        r.den = ad;
        r.zd  = (ad == 0);
      end
      OP_REDUCE: begin
        if (ad == 0) begin
          r.num = an;
          r.den = ad;
          r.zd  = 1'b1;
        end else begin
          g = euclid(mag32(an), mag32(ad));
          r.num = an[31] ? -(mag32(an) / g) : mag32(an) / g;
          r.den = ad[31] ? -(mag32(ad) / g) : mag32(ad) / g;
          if (r.den[31]) begin
            r.num = -r.num;
            r.den = -r.den;
          end
          r.zd = (r.den == 0);
        end
      end
      OP_EQ, OP_GT: begin
        if (ad == 0 || bd == 0) begin
          r.zd = 1'b1;
        end else begin
          // Exact cross products; the sign flips when the denominators differ in sign.
          p1 = $signed(an) * $signed(bd);
          p2 = $signed(bn) * $signed(ad);
          if (ad[31] != bd[31]) begin
            p1 = -p1;
            p2 = -p2;
          end
          r.cmp = (op == OP_EQ) ? (p1 == p2) : (p1 > p2);
        end
      end
      OP_TOINT: begin
        r.num = quot32(an, ad);
        r.den = 32'd1;
        r.zd  = (ad == 0);
      end
      default: ;
    endcase
    return r;
  endfunction

  class frac_scoreboard;
    frac_res_t pending[$];
    int        errors;

    function void note_word(logic [3:0] op, logic [31:0] an, logic [31:0] ad,
                            logic [31:0] bn, logic [31:0] bd);
      pending.push_back(rational_op(op, an, ad, bn, bd));
    endfunction

    function void check_word(logic [31:0] num, logic [31:0] den, logic cmp, logic zd);
      frac_res_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h/%h", num, den);
        return;
      end
      e = pending.pop_front();
      if (e.num !== num || e.den !== den || e.cmp !== cmp || e.zd !== zd) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %h/%h cmp %b zd %b, got %h/%h cmp %b zd %b",
                   e.num, e.den, e.cmp, e.zd, num, den, cmp, zd);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [3:0]  op_i = '0;
  word_t       a_num_i = '0, a_den_i = '0, b_num_i = '0, b_den_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  word_t       res_num_o, res_den_o;
  logic        cmp_true_o, zero_den_o;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          quiet_cycles = 0;
  frac_scoreboard fsb = new();

  localparam int WATCHDOG_LIMIT = 50000;

  always #5 clk_i = ~clk_i;

  rational_arithmetic_unit DUT (.*);

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i)
      fsb.check_word(res_num_o, res_den_o, cmp_true_o, zero_den_o);
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Presents one word, optionally after a random idle gap, and waits for it.
  // Valid stays high from one word to the next unless an idle gap comes.
  task automatic send_word(logic [3:0] op, word_t an, word_t ad, word_t bn, word_t bd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    a_num_i <= an;
    a_den_i <= ad;
    b_num_i <= bn;
    b_den_i <= bd;
    do @(posedge clk_i); while (in_stall_o);
    fsb.note_word(op, an, ad, bn, bd);
  endtask

  function automatic word_t rand_den();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      3:       return 32'hFFFF_FFFF;
      default: return word_t'($signed($urandom_range(24)) - 12);
    endcase
  endfunction

  function automatic word_t rand_num();
    case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'h8000_0000;
      2:       return 32'h7FFF_FFFF;
      default: return word_t'($signed($urandom_range(200)) - 100);
    endcase
  endfunction

  initial begin
    word_t ext[6];
    ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd6};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words: every operation, zero denominators, wrap cases.
    send_word(OP_ADD, 32'd1, 32'd6, 32'd1, 32'd4);
    send_word(OP_SUB, 32'd1, 32'd6, 32'd1, 32'd0);
    send_word(OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd2);
    send_word(OP_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
    send_word(OP_NEG, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
    send_word(OP_REDUCE, 32'd12, 32'hFFFF_FFF8, 32'd0, 32'd1);
    send_word(OP_REDUCE, 32'd7, 32'd0, 32'd0, 32'd1);
    send_word(OP_REDUCE, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd1);
    send_word(OP_EQ, 32'd2, 32'd4, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_word(OP_EQ, 32'd2, 32'd0, 32'd1, 32'd2);
    send_word(OP_GT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_GT, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1);
    send_word(OP_TOINT, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1);
    send_word(OP_TOINT, 32'd5, 32'd0, 32'd0, 32'd1);
    send_word(4'd9, 32'd1, 32'd1, 32'd1, 32'd1);
    send_word(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++)
      send_word(4'(i % 9), ext[i], ext[5 - i], ext[(i + 2) % 6], ext[(i + 4) % 6]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 8 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 8 : 0;
      for (int i = 0; i < 310; i++)
        send_word(($urandom_range(19) == 0) ? 4'($urandom_range(15, 9))
                                            : 4'($urandom_range(8)),
                  rand_num(), rand_den(), rand_num(), rand_den());
    end
    in_valid_i <= 1'b0;

    while (fsb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fsb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/rau_pkg.sv
hw/rtl/rau_muldiv.sv
hw/rtl/rational_arithmetic_unit.sv
tb/rational_arithmetic_unit_tb.sv
